### hdl/skt_pkg.sv
package skt_pkg;

  // Request kinds carried in req_type.
  localparam logic [1:0] REQ_SEARCH = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_DELETE = 2'd2;

  // Status codes returned with every result.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_AUTO_OVF  = 3'd4;

  // Field widths fixed by the item format.
  localparam int KEY_W  = 32;
  localparam int POS_W  = 8;
  localparam int STAT_W = 3;
  localparam int CAP_W  = 9;

  // Configuration port: register index is paddr[PADDR_W-1:2].
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic CFG_CAPACITY = 1'b0;
  localparam logic [CAP_W-1:0] CAPACITY_RESET = 9'd256;

  // Largest signed key, beyond which an automatic key cannot be issued.
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

endpackage

### hdl/skt_req_if.sv
interface skt_req_if
  import skt_pkg::*;
#(
  parameter int PAYLOAD_BITS = 16
);
  logic                    valid;
  logic                    ready;
  logic [1:0]              req_type;
  logic signed [KEY_W-1:0] key;
  logic                    auto_key;
  logic [PAYLOAD_BITS-1:0] payload;

  modport source (output valid, req_type, key, auto_key, payload, input ready);
  modport sink (input valid, req_type, key, auto_key, payload, output ready);
endinterface

### hdl/skt_rsp_if.sv
interface skt_rsp_if
  import skt_pkg::*;
#(
  parameter int PAYLOAD_BITS = 16
);
  logic                    valid;
  logic                    ready;
  logic [STAT_W-1:0]       status;
  logic [POS_W-1:0]        position;
  logic signed [KEY_W-1:0] key_out;
  logic [PAYLOAD_BITS-1:0] payload_out;

  modport source (output valid, status, position, key_out, payload_out, input ready);
  modport sink (input valid, status, position, key_out, payload_out, output ready);
endinterface

### hdl/skt_ram.sv
module skt_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/sorted_key_table.sv
// Sorted key table: unique signed 32-bit keys with a payload handle each, held in
// ascending order in one single-port-read, single-port-write RAM. One request is
// handled at a time. A search makes P binary-search probes, where P is at most
// log2(entries)+1 rounded down; each probe waits for the registered RAM read. An insert
// or a delete then shifts every entry that moves, streaming through the RAM with one
// read and one write per cycle. The next request is taken while the previous result
// still waits in the output register. The RAM needs no clearing after reset; only
// entries below the entry count are ever used.
module sorted_key_table
  import skt_pkg::*;
#(
  parameter int TABLE_DEPTH  = 256,
  parameter int PAYLOAD_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  skt_req_if.sink            req,
  skt_rsp_if.source          rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int LW = (CW > CAP_W) ? CW : CAP_W;
  localparam int MW = KEY_W + PAYLOAD_BITS;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SEARCH = 6'b000010,
    S_CMP    = 6'b000100,
    S_CHECK  = 6'b001000,
    S_SHIFT  = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t                  state;
  logic [CAP_W-1:0]        capacity;
  logic [CW-1:0]           cnt;
  logic signed [KEY_W-1:0] hw;

  // Per-request working registers.
  logic [1:0]              op;
  logic signed [KEY_W-1:0] k;
  logic [PAYLOAD_BITS-1:0] pay;
  logic [CW-1:0]           lo;
  logic [CW-1:0]           hi;
  logic [CW-1:0]           mid;
  logic [IW-1:0]           pos;
  logic                    chk;
  logic [IW-1:0]           src;
  logic [IW-1:0]           dst;
  logic [CW-1:0]           rem;
  logic                    pend;
  logic [STAT_W-1:0]       res_status;
  logic [PAYLOAD_BITS-1:0] res_pay;

  // Output register.
  logic                    out_valid;
  logic [STAT_W-1:0]       out_status;
  logic [POS_W-1:0]        out_pos;
  logic signed [KEY_W-1:0] out_key;
  logic [PAYLOAD_BITS-1:0] out_pay;

  // RAM ports.
  logic                    we;
  logic [IW-1:0]           waddr;
  logic [MW-1:0]           wdata;
  logic [IW-1:0]           raddr;
  logic [MW-1:0]           rdata;
  logic signed [KEY_W-1:0] rd_key;
  logic [PAYLOAD_BITS-1:0] rd_pay;

  logic [CW:0]             mid_sum;
  logic [CW-1:0]           mid_w;
  logic [LW-1:0]           cap_ext;
  logic [LW-1:0]           depth_ext;
  logic                    full;
  logic                    match;
  logic                    accept;
  logic                    ins;

  skt_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (MW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_key = $signed(rdata[PAYLOAD_BITS +: KEY_W]);
  assign rd_pay = rdata[PAYLOAD_BITS-1:0];

  // Configuration port: capacity is the only register.
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1:2] == CFG_CAPACITY) ? PDATA_W'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (psel && penable && pwrite && paddr[PADDR_W-1:2] == CFG_CAPACITY) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  // The table is full at the smaller of the capacity and the RAM depth.
  assign cap_ext   = LW'(capacity);
  assign depth_ext = LW'(TABLE_DEPTH);
  assign full      = LW'(cnt) >= ((cap_ext < depth_ext) ? cap_ext : depth_ext);

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid_w   = mid_sum[CW:1];
  assign match   = chk && (rd_key == k);
  assign ins     = (op == REQ_INSERT);
  assign accept  = req.valid && req.ready;

  // Read address: the probe, or the final position for the check, during the search; the shift source otherwise.
  always_comb begin
    if (state == S_SEARCH) begin
      raddr = (lo < hi) ? mid_w[IW-1:0] : lo[IW-1:0];
    end else begin
      raddr = src;
    end
  end

  // Writes: a moved entry when its read returns, then the new entry on insert.
  always_comb begin
    we    = 1'b0;
    waddr = dst;
    wdata = rdata;
    if (state == S_SHIFT) begin
      if (pend) begin
        we = 1'b1;
      end else if (rem == '0 && ins) begin
        we    = 1'b1;
        waddr = pos;
        wdata = {k, pay};
      end
    end
  end

  // Request sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      hw        <= '0;
      out_valid <= 1'b0;
    end else begin
      // A taken result frees the output register unless a new one is loaded now.
      if (rsp.valid && rsp.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op   <= req.req_type;
            pay  <= req.payload;
            lo   <= '0;
            hi   <= cnt;
            pos  <= '0;
            pend <= 1'b0;
            if (req.req_type == REQ_INSERT && full) begin
              res_status <= ST_FULL;
              res_pay    <= '0;
              k          <= req.key;
              state      <= S_DONE;
            end else if (req.req_type == REQ_INSERT && req.auto_key && hw == KEY_MAX) begin
              res_status <= ST_AUTO_OVF;
              res_pay    <= '0;
              k          <= hw;
              state      <= S_DONE;
            end else begin
              k     <= (req.req_type == REQ_INSERT && req.auto_key) ? hw + 32'sd1 : req.key;
              state <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          if (lo < hi) begin
            mid   <= mid_w;
            state <= S_CMP;
          end else begin
            pos   <= lo[IW-1:0];
            chk   <= (lo < cnt);
            state <= S_CHECK;
          end
        end
        S_CMP: begin
          if (rd_key < k) begin
            lo <= mid + CW'(1);
          end else begin
            hi <= mid;
          end
          state <= S_SEARCH;
        end
        S_CHECK: begin
          if (ins) begin
            if (match) begin
              res_status <= ST_DUPLICATE;
              res_pay    <= rd_pay;
              state      <= S_DONE;
            end else begin
              res_status <= ST_OK;
              res_pay    <= pay;
              rem        <= cnt - lo;
              src        <= IW'(cnt - CW'(1));
              state      <= S_SHIFT;
            end
          end else if (!match) begin
            res_status <= ST_NOT_FOUND;
            res_pay    <= '0;
            pos        <= '0;
            state      <= S_DONE;
          end else begin
            res_status <= ST_OK;
            res_pay    <= rd_pay;
            if (op == REQ_DELETE) begin
              rem   <= cnt - CW'(1) - lo;
              src   <= pos + IW'(1);
              state <= S_SHIFT;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_SHIFT: begin
          if (rem != '0) begin
            pend <= 1'b1;
            dst  <= ins ? src + IW'(1) : src - IW'(1);
            src  <= ins ? src - IW'(1) : src + IW'(1);
            rem  <= rem - CW'(1);
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              if (ins) begin
                cnt <= cnt + CW'(1);
                if (cnt == '0 || k > hw) begin
                  hw <= k;
                end
              end else begin
                cnt <= cnt - CW'(1);
              end
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_pos    <= POS_W'(pos);
            out_key    <= k;
            out_pay    <= res_pay;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.position    = out_pos;
  assign rsp.key_out     = out_key;
  assign rsp.payload_out = out_pay;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    LW'(cnt) <= depth_ext)
    else $error("entry count exceeds the table depth");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("accepted request left the sequencer idle");

  a_write_in_shift: assert property (@(posedge clk) disable iff (rst)
    we |-> state == S_SHIFT)
    else $error("RAM written outside the shift phase");

  a_cnt_only_in_shift: assert property (@(posedge clk) disable iff (rst)
    state != S_SHIFT |=> $stable(cnt))
    else $error("entry count changed outside the shift phase");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.status <= ST_AUTO_OVF)
    else $error("result carries an undefined status code");
`endif

endmodule
